// File: rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    // default screen geometry limits
    localparam int DEF_MAX_COLUMNS = 80;
    localparam int DEF_MAX_ROWS    = 25;

    // register values after reset
    localparam int RST_COLUMNS = 80;
    localparam int RST_ROWS    = 25;

    // geometry register bounds
    localparam int MIN_COLUMNS = 1;
    localparam int MIN_ROWS    = 2;

    // cell contents
    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]  TEXT_ATTR  = 8'h07;

    // character codes
    localparam logic [7:0] CH_BACKSPACE  = 8'h08;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
    localparam logic [7:0] CH_LAST_PRINT  = 8'h7E;

    // configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // operations
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

endpackage

`default_nettype wire

// File: rtl/text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// Text screen of 16-bit cells with cursor, character write, clear, cell read
// and scroll up.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result item for it.
// A character write (printable, newline, backspace or ignored code) is done
// in the execute state, a read inside the store in the execute and read
// states. A clear sweeps the whole cell store, one cell per cycle. A write
// that scrolls copies (rows-1)*columns cells and blanks one row through the
// single write port of the cell store. After reset the store is blanked by
// a sweep of every cell, during which no item is taken; configuration
// writes are taken at any time. Row and column products come from one
// shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer_unit #(
    parameter int MAX_COLUMNS = tccw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tccw_pkg::DEF_MAX_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    // input items
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // char_code[7:0], cell_index[18:8], zero fill
    input  wire logic [1:0]  i_s_tuser,   // op[1:0]
    // result items
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata    // cursor_row[4:0], cursor_col[11:5],
                                          // cell_value[27:12], scrolled[28], zero fill
);

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int AW  = $clog2(CELL_COUNT);
    localparam int CW  = $clog2(CELL_COUNT + 1);
    localparam int CNW = $clog2(MAX_COLUMNS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int PW  = CNW + RNW;
    localparam int RST_COLS_EFF =
        (tccw_pkg::RST_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : tccw_pkg::RST_COLUMNS;
    localparam int RST_ROWS_EFF =
        (tccw_pkg::RST_ROWS > MAX_ROWS) ? MAX_ROWS : tccw_pkg::RST_ROWS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_SETUP  = 7'b0001000,
        S_SCROLL = 7'b0010000,
        S_FILL   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CNW-1:0] r_cols, n_cols;
    logic [RNW-1:0] r_rows, n_rows;
    logic [RNW-1:0] r_row, n_row;
    logic [CNW-1:0] r_col, n_col;
    logic [CW-1:0]  r_wa, n_wa;
    logic [CW-1:0]  r_end, n_end;
    logic [CW-1:0]  r_src, n_src;
    logic [CW-1:0]  r_src_end, n_src_end;
    logic           r_cp_vld, n_cp_vld;
    logic           r_init, n_init;
    tccw_pkg::t_op  r_op, n_op;
    logic [7:0]     r_char, n_char;
    logic [10:0]    r_idx, n_idx;
    logic [15:0]    r_val, n_val;
    logic           r_scr, n_scr;

    logic           r_m_valid;
    logic [4:0]     r_o_row;
    logic [6:0]     r_o_col;
    logic [15:0]    r_o_val;
    logic           r_o_scr;

    // cell store
    logic [15:0]    mem [CELL_COUNT];
    logic [15:0]    r_rd_data;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [15:0]    mem_wd;
    logic [AW-1:0]  mem_ra;

    // shared multiplier
    logic [RNW-1:0] mul_a;
    logic [PW-1:0]  prod;

    logic           out_free;
    logic           fin;
    logic           out_load;
    logic           is_nl, is_bs, is_pr;
    logic [CNW-1:0] col_sel;
    logic [CW-1:0]  cell_addr;
    logic [RNW-1:0] row_inc;
    logic [CNW-1:0] col_inc;
    logic           idx_ok;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {3'b000, r_o_scr, r_o_val, r_o_col, r_o_row};

    assign out_free = !r_m_valid || i_m_tready;

    assign mul_a     = (r_state == S_SETUP) ? (r_rows - RNW'(1)) : r_row;
    assign prod      = PW'(mul_a) * PW'(r_cols);

    assign is_nl     = (r_char == tccw_pkg::CH_NEWLINE);
    assign is_bs     = (r_char == tccw_pkg::CH_BACKSPACE);
    assign is_pr     = (r_char >= tccw_pkg::CH_FIRST_PRINT) &&
                       (r_char <= tccw_pkg::CH_LAST_PRINT);
    assign col_sel   = is_bs ? (r_col - CNW'(1)) : r_col;
    assign cell_addr = CW'(prod) + CW'(col_sel);
    assign row_inc   = r_row + RNW'(1);
    assign col_inc   = r_col + CNW'(1);
    assign idx_ok    = (32'(r_idx) < CELL_COUNT);

    always_comb begin
        n_state   = r_state;
        n_cols    = r_cols;
        n_rows    = r_rows;
        n_row     = r_row;
        n_col     = r_col;
        n_wa      = r_wa;
        n_end     = r_end;
        n_src     = r_src;
        n_src_end = r_src_end;
        n_cp_vld  = r_cp_vld;
        n_init    = r_init;
        n_op      = r_op;
        n_char    = r_char;
        n_idx     = r_idx;
        n_val     = r_val;
        n_scr     = r_scr;
        fin       = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = AW'(r_wa);
        mem_wd    = tccw_pkg::BLANK_CELL;
        mem_ra    = AW'(r_src);

        // geometry registers, held clamped to their legal range
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tccw_pkg::CFG_COLUMNS: begin
                    if (i_cfg_data < 7'(tccw_pkg::MIN_COLUMNS)) begin
                        n_cols = CNW'(tccw_pkg::MIN_COLUMNS);
                    end else if (32'(i_cfg_data) > MAX_COLUMNS) begin
                        n_cols = CNW'(MAX_COLUMNS);
                    end else begin
                        n_cols = CNW'(i_cfg_data);
                    end
                end
                tccw_pkg::CFG_ROWS: begin
                    if (i_cfg_data[4:0] < 5'(tccw_pkg::MIN_ROWS)) begin
                        n_rows = RNW'(tccw_pkg::MIN_ROWS);
                    end else if (32'(i_cfg_data[4:0]) > MAX_ROWS) begin
                        n_rows = RNW'(MAX_ROWS);
                    end else begin
                        n_rows = RNW'(i_cfg_data[4:0]);
                    end
                end
                default: begin
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op    = tccw_pkg::t_op'(i_s_tuser);
                    n_char  = i_s_tdata[7:0];
                    n_idx   = i_s_tdata[18:8];
                    n_row   = (r_row >= r_rows) ? (r_rows - RNW'(1)) : r_row;
                    n_col   = (r_col >= r_cols) ? (r_cols - CNW'(1)) : r_col;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_val  = 16'h0000;
                n_scr  = 1'b0;
                mem_wa = AW'(cell_addr);
                mem_ra = AW'(r_idx);
                unique case (r_op)
                    tccw_pkg::OP_WRITE: begin
                        if (is_nl) begin
                            n_row = row_inc;
                            n_col = '0;
                        end else if (is_bs) begin
                            if (r_col != '0) begin
                                n_col  = col_sel;
                                mem_we = 1'b1;
                            end
                        end else if (is_pr) begin
                            mem_we = 1'b1;
                            mem_wd = {tccw_pkg::TEXT_ATTR, r_char};
                            if (col_inc >= r_cols) begin
                                n_row = row_inc;
                                n_col = '0;
                            end else begin
                                n_col = col_inc;
                            end
                        end
                        if (n_row >= r_rows) begin
                            n_row   = r_rows - RNW'(1);
                            n_scr   = 1'b1;
                            n_state = S_SETUP;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    tccw_pkg::OP_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_wa    = '0;
                        n_end   = CW'(CELL_COUNT);
                        n_state = S_FILL;
                    end
                    tccw_pkg::OP_READ: begin
                        if (idx_ok) begin
                            n_state = S_READ;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                n_val = r_rd_data;
                fin   = 1'b1;
            end
            S_SETUP: begin
                n_end     = CW'(prod);
                n_src_end = CW'(prod) + CW'(r_cols);
                n_src     = CW'(r_cols);
                n_wa      = '0;
                n_cp_vld  = 1'b0;
                n_state   = S_SCROLL;
            end
            S_SCROLL: begin
                // read runs one cell ahead of the write
                if (r_src != r_src_end) begin
                    n_src    = r_src + CW'(1);
                    n_cp_vld = 1'b1;
                end else begin
                    n_cp_vld = 1'b0;
                end
                if (r_cp_vld) begin
                    mem_we = 1'b1;
                    mem_wd = r_rd_data;
                    if (r_wa == r_end - CW'(1)) begin
                        n_wa     = r_end;
                        n_end    = r_end + CW'(r_cols);
                        n_cp_vld = 1'b0;
                        n_state  = S_FILL;
                    end else begin
                        n_wa = r_wa + CW'(1);
                    end
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (r_wa == r_end - CW'(1)) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    n_wa = r_wa + CW'(1);
                end
            end
            S_DONE: begin
                fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = out_free ? S_IDLE : S_DONE;
        end
    end

    assign out_load = fin && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_cols    <= CNW'(RST_COLS_EFF);
            r_rows    <= RNW'(RST_ROWS_EFF);
            r_row     <= '0;
            r_col     <= '0;
            r_wa      <= '0;
            r_end     <= CW'(CELL_COUNT);
            r_src     <= '0;
            r_src_end <= '0;
            r_cp_vld  <= 1'b0;
            r_init    <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cols    <= n_cols;
            r_rows    <= n_rows;
            r_row     <= n_row;
            r_col     <= n_col;
            r_wa      <= n_wa;
            r_end     <= n_end;
            r_src     <= n_src;
            r_src_end <= n_src_end;
            r_cp_vld  <= n_cp_vld;
            r_init    <= n_init;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_char <= n_char;
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_scr  <= n_scr;
        if (out_load) begin
            r_o_row <= 5'(n_row);
            r_o_col <= 7'(n_col);
            r_o_val <= n_val;
            r_o_scr <= n_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

endmodule

`default_nettype wire

// File: test/text_console_cell_writer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_checker
// Watches the configuration, input and result channels of the console cell
// writer, keeps its own copy of the screen, cursor and geometry, predicts
// the result of every accepted item and compares it field by field with
// the result items in order.
// ----------------------------------------------------------------------------
module text_console_cell_writer_checker #(
    parameter int MAX_COLUMNS = tccw_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tccw_pkg::DEF_MAX_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [23:0] i_s_tdata,   // char_code[7:0], cell_index[18:8], zero fill
    input  wire logic [1:0]  i_s_tuser,   // op[1:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                          // cell_value[27:12], scrolled[28], zero fill
    output int               o_fail_count,
    output int               o_pending
);
    import tccw_pkg::*;

    localparam int CELL_TOTAL = MAX_COLUMNS * MAX_ROWS;

    typedef struct packed {
        logic        scrolled;
        logic [15:0] cell_val;
        logic [6:0]  col;
        logic [4:0]  row;
    } console_result_t;

    logic [15:0]     screen_q [0:CELL_TOTAL-1];
    int unsigned     cur_row;
    int unsigned     cur_col;
    logic [6:0]      columns_reg;
    logic [4:0]      rows_reg;
    console_result_t expected_q [$];
    console_result_t want;
    console_result_t got;
    int              fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic predict_console(input logic [1:0] op, input logic [7:0] ch,
                                   input logic [10:0] idx, output console_result_t res);
        int unsigned cols;
        int unsigned rows;
        int unsigned i;
        logic [15:0] value;
        logic        scr;
        cols = 32'(columns_reg);
        rows = 32'(rows_reg);
        if (cols < MIN_COLUMNS) cols = MIN_COLUMNS;
        if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
        if (rows < MIN_ROWS) rows = MIN_ROWS;
        if (rows > MAX_ROWS) rows = MAX_ROWS;
        value = 16'h0000;
        scr   = 1'b0;
        if (cur_row >= rows) cur_row = rows - 1;
        if (cur_col >= cols) cur_col = cols - 1;
        case (op)
            OP_WRITE: begin
                if (ch == CH_NEWLINE) begin
                    cur_row++;
                    cur_col = 0;
                end else if (ch == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen_q[cur_row * cols + cur_col] = BLANK_CELL;
                    end
                end else if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
                    screen_q[cur_row * cols + cur_col] = {TEXT_ATTR, ch};
                    cur_col++;
                    if (cur_col >= cols) begin
                        cur_row++;
                        cur_col = 0;
                    end
                end
                if (cur_row >= rows) begin
                    for (i = 0; i < (rows - 1) * cols; i++)
                        screen_q[i] = screen_q[i + cols];
                    for (i = (rows - 1) * cols; i < rows * cols; i++)
                        screen_q[i] = BLANK_CELL;
                    cur_row = rows - 1;
                    scr     = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (i = 0; i < CELL_TOTAL; i++)
                    screen_q[i] = BLANK_CELL;
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ: begin
                if (32'(idx) < CELL_TOTAL)
                    value = screen_q[idx];
            end
            default: ;
        endcase
        res.row      = cur_row[4:0];
        res.col      = cur_col[6:0];
        res.cell_val = value;
        res.scrolled = scr;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_TOTAL; i++)
                screen_q[i] = BLANK_CELL;
            cur_row     = 0;
            cur_col     = 0;
            columns_reg = 7'(RST_COLUMNS);
            rows_reg    = 5'(RST_ROWS);
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_COLUMNS)
                    columns_reg = i_cfg_data;
                else
                    rows_reg = i_cfg_data[4:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_console(i_s_tuser, i_s_tdata[7:0], i_s_tdata[18:8], want);
                expected_q.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[28:0];
                if (expected_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected result item %h", i_m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (got.row !== want.row || got.col !== want.col ||
                        got.cell_val !== want.cell_val || got.scrolled !== want.scrolled) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("mismatch: expected row %0d col %0d cell %h scr %0d, %s",
                                     want.row, want.col, want.cell_val, want.scrolled,
                                     $sformatf("got row %0d col %0d cell %h scr %0d",
                                               got.row, got.col, got.cell_val, got.scrolled));
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_q.size();
    end

endmodule

// File: test/text_console_cell_writer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit_tb
// Drives the console cell writer with directed items (printable limits,
// control codes, ignored codes, reads past the store, clear, scroll and
// clamped geometry) and then random items over a series of screen
// geometries, with random gaps on both channels outside one quiet phase. A
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit_tb;
    import tccw_pkg::*;

    localparam int MAX_COLUMNS = DEF_MAX_COLUMNS;
    localparam int MAX_ROWS    = DEF_MAX_ROWS;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int PHASE_COUNT = 13;
    localparam int QUIET_PHASE = 5;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_COLUMNS;
    logic [6:0]  i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [23:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = OP_WRITE;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    logic        idle_on     = 1'b1;

    int phase_cols  [0:PHASE_COUNT-1] = '{127, 1, 5, 12, 80, 2, 0, 20, 7, 33, 80, 3, 9};
    int phase_rows  [0:PHASE_COUNT-1] = '{31, 2, 3, 4, 2, 25, 0, 6, 9, 3, 25, 30, 5};
    int phase_items [0:PHASE_COUNT-1] = '{60, 150, 200, 200, 150, 150, 100, 200, 200,
                                          150, 60, 200, 130};

    text_console_cell_writer_unit #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    text_console_cell_writer_checker #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_cell_writer_unit_tb failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [10:0] idx);
        while (idle_on && $urandom_range(99) < 36) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {5'b0, idx, ch};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_random_item(input int cols, input int rows);
        int          pick;
        int          kind;
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [10:0] idx;
        pick = $urandom_range(99);
        ch   = 8'($urandom_range(255));
        idx  = 11'($urandom_range(2047));
        op   = OP_WRITE;
        if (pick < 2) begin
            op = OP_CLEAR;
        end else if (pick < 5) begin
            op = OP_UNUSED;
        end else if (pick < 27) begin
            op = OP_READ;
            if ($urandom_range(9) < 7) idx = 11'($urandom_range(cols * rows - 1));
        end else begin
            kind = $urandom_range(99);
            if (kind < 55) ch = 8'($urandom_range(CH_LAST_PRINT, CH_FIRST_PRINT));
            else if (kind < 72) ch = CH_NEWLINE;
            else if (kind < 88) ch = CH_BACKSPACE;
        end
        send_item(op, ch, idx);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic [6:0] cols, input logic [6:0] rows);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_COLUMNS;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= rows;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int cols_eff;
        int rows_eff;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: printable limits, ignored codes, control codes, reads, clear
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_WRITE, CH_FIRST_PRINT, 11'd0);
        send_item(OP_WRITE, CH_LAST_PRINT, 11'd0);
        send_item(OP_WRITE, 8'h1F, 11'd0);
        send_item(OP_WRITE, 8'h7F, 11'd0);
        send_item(OP_WRITE, 8'hFF, 11'h7FF);
        send_item(OP_WRITE, CH_BACKSPACE, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1);
        send_item(OP_READ, 8'hFF, 11'd0);
        send_item(OP_WRITE, CH_NEWLINE, 11'd0);
        send_item(OP_WRITE, CH_BACKSPACE, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1999);
        send_item(OP_READ, 8'h00, 11'd2047);
        send_item(OP_UNUSED, 8'h41, 11'd5);
        send_item(OP_CLEAR, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd0);

        // registers below range: one column, two rows, scroll on the second write
        write_geometry(7'd0, 7'd1);
        send_item(OP_WRITE, 8'h41, 11'd0);
        send_item(OP_WRITE, 8'h42, 11'd0);
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1);
        send_item(OP_WRITE, CH_NEWLINE, 11'd0);
        send_item(OP_WRITE, CH_BACKSPACE, 11'd0);
        send_item(OP_READ, 8'h00, 11'd0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_geometry(phase_cols[p][6:0], phase_rows[p][6:0]);
            cols_eff = phase_cols[p];
            rows_eff = phase_rows[p];
            if (cols_eff < MIN_COLUMNS) cols_eff = MIN_COLUMNS;
            if (cols_eff > MAX_COLUMNS) cols_eff = MAX_COLUMNS;
            if (rows_eff < MIN_ROWS) rows_eff = MIN_ROWS;
            if (rows_eff > MAX_ROWS) rows_eff = MAX_ROWS;
            idle_on <= (p != QUIET_PHASE);
            for (int n = 0; n < phase_items[p]; n++) begin
                send_random_item(cols_eff, rows_eff);
                if ($urandom_range(199) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("text_console_cell_writer_unit_tb passed");
        else
            $display("text_console_cell_writer_unit_tb failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/tccw_pkg.sv
rtl/text_console_cell_writer_unit.sv
test/text_console_cell_writer_checker.sv
test/text_console_cell_writer_unit_tb.sv
